FILE: design/rtcs_pkg.sv
package rtcs_pkg;

   // Number of RAM bytes behind the link.
   localparam int RAM_DEPTH = 31;
   localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   // Clock register file and its special members.
   localparam int          CLOCK_REGS   = 8;
   localparam logic [4:0]  BURST_ADDR   = 5'd31;
   localparam logic [4:0]  WP_INDEX     = 5'd7;
   localparam logic [4:0]  POS_MAX      = 5'd31;
   localparam logic [5:0]  RAM_LIMIT    = 6'(RAM_DEPTH);
   localparam logic [5:0]  CLOCK_LIMIT  = 6'(CLOCK_REGS);

   // Command byte fields.
   localparam int CMD_VALID_BIT = 7;
   localparam int CMD_RAM_BIT   = 6;
   localparam int CMD_READ_BIT  = 0;

   // One input item.
   typedef struct packed {
      logic       frame_start;
      logic [7:0] byte_in;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [7:0] read_byte;
      logic       read_valid;
      logic       write_done;
   } rsp_type;

   // Decoded access for one data slot.
   typedef struct packed {
      logic       hit;
      logic       is_ram;
      logic       is_read;
      logic [4:0] index;
   } access_type;

endpackage

FILE: design/rtcs_frame.sv
module rtcs_frame
   import rtcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  req_type    item,
   output access_type access
);

   logic [7:0] cmd_ff, cmd_in;
   logic [4:0] pos_ff, pos_in;
   logic       open_ff, open_in;
   logic       burst;
   logic [4:0] addr;

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff  <= '0;
         pos_ff  <= '0;
         open_ff <= 1'b0;
      end else if (step) begin
         cmd_ff  <= cmd_in;
         pos_ff  <= pos_in;
         open_ff <= open_in;
      end
   end

   // Decode the slot and advance the position within the frame.
   always_comb begin
      addr    = cmd_ff[5:1];
      burst   = (addr == BURST_ADDR);
      cmd_in  = cmd_ff;
      pos_in  = pos_ff;
      open_in = open_ff;
      access  = '0;
      if (item.frame_start) begin
         cmd_in  = item.byte_in;
         pos_in  = '0;
         open_in = item.byte_in[CMD_VALID_BIT];
      end else if (open_ff) begin
         access.is_ram  = cmd_ff[CMD_RAM_BIT];
         access.is_read = cmd_ff[CMD_READ_BIT];
         access.index   = burst ? pos_ff : addr;
         if (burst || (pos_ff == '0)) begin
            access.hit = access.is_ram ? ({1'b0, access.index} < RAM_LIMIT)
                                       : ({1'b0, access.index} < CLOCK_LIMIT);
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 5'd1;
         end
      end
   end

endmodule

FILE: design/rtcs_store.sv
module rtcs_store
   import rtcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  access_type access,
   input  logic [7:0] wr_data,
   output rsp_type    result
);

   logic [7:0] clk_regs_ff [CLOCK_REGS];
   logic [7:0] ram_ff      [RAM_DEPTH];
   logic       protect;
   logic       is_wp;
   logic       wr_en;
   logic [2:0] clk_idx;
   logic [RAM_AW-1:0] ram_idx;

   assign clk_idx = access.index[2:0];
   assign ram_idx = access.index[RAM_AW-1:0];

   // Write protect applies to everything but the protect word itself.
   always_comb begin
      protect = clk_regs_ff[WP_INDEX[2:0]][7];
      is_wp   = !access.is_ram && (access.index == WP_INDEX);
      wr_en   = access.hit && !access.is_read && (!protect || is_wp);
      result  = '0;
      if (access.hit && access.is_read) begin
         result.read_valid = 1'b1;
         result.read_byte  = access.is_ram ? ram_ff[ram_idx] : clk_regs_ff[clk_idx];
      end
      result.write_done = wr_en;
   end

   // Clock registers and RAM bytes, both cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLOCK_REGS; i++) clk_regs_ff[i] <= '0;
         for (int i = 0; i < RAM_DEPTH; i++)  ram_ff[i]      <= '0;
      end else if (step && wr_en) begin
         if (access.is_ram) begin
            ram_ff[ram_idx] <= wr_data;
         end else begin
            clk_regs_ff[clk_idx] <= wr_data;
         end
      end
   end

endmodule

FILE: design/rtc_three_wire_register_slave_unit.sv
// An accepted item waits in the input register and moves on to the result
// register once that is free. Throughput: one item per cycle while rsp_ready
// stays high; each register holds one item, and the register file is read and
// written in one pass. Reset clears all clock registers, RAM bytes and frame
// state, and empties both pipeline registers.
module rtc_three_wire_register_slave_unit
   import rtcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic       in_valid_ff;
   req_type    in_data_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;
   logic       advance;
   access_type access;
   rsp_type    result;

   // The held item moves on when the result register is free.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   rtcs_frame u_frame (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .access (access)
   );

   rtcs_store u_store (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .access  (access),
      .wr_data (in_data_ff.byte_in),
      .result  (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

endmodule

FILE: design/rtcs_checker.sv
module rtcs_checker
   import rtcs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A slot is either a read or a write, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.read_valid && rsp_data.write_done))
      else $error("read and write reported for the same item");

   // Read data is zero unless a read was served.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.read_valid) |-> (rsp_data.read_byte == '0))
      else $error("nonzero read byte without a served read");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result item changed");

   // With no result pending the input side can always take an item.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result register");

   // Reset empties the result side.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind rtc_three_wire_register_slave_unit rtcs_checker u_rtcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: sim/tb_rtc_three_wire_register_slave_unit.sv
`timescale 1ns / 100ps

module tb_rtc_three_wire_register_slave_unit;
   import rtcs_pkg::*;

   localparam int RUN_LIMIT       = 200000;
   localparam int RANDOM_ITEMS    = 550;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 8;
   localparam int REPORT_LIMIT    = 10;

   // Command field selectors, so command bytes are built by name.
   localparam logic SEL_CLOCK = 1'b0;
   localparam logic SEL_RAM   = 1'b1;
   localparam logic DIR_WRITE = 1'b0;
   localparam logic DIR_READ  = 1'b1;

   // Shadow copy of the register file and frame state, plus the replies
   // that the block still owes, oldest first.
   class rtc_reply_tracker;
      logic [7:0] clock_shadow [CLOCK_REGS];
      logic [7:0] ram_shadow [32];
      logic [7:0] open_command;
      logic [4:0] slot_index;
      logic       frame_live;
      rsp_type    owed_replies [$];
      int         fault_count;

      function new();
         foreach (clock_shadow[i]) clock_shadow[i] = '0;
         foreach (ram_shadow[i]) ram_shadow[i] = '0;
         open_command = '0;
         slot_index   = '0;
         frame_live   = 1'b0;
         fault_count  = 0;
      endfunction

      // Work out the reply to one accepted item and update the shadow state.
      function void note_byte(req_type item);
         rsp_type    reply;
         logic       is_ram;
         logic       is_read;
         logic       hit;
         logic [4:0] addr;
         logic [4:0] target;
         reply  = '0;
         hit    = 1'b0;
         target = '0;
         if (item.frame_start) begin
            open_command = item.byte_in;
            slot_index   = '0;
            frame_live   = item.byte_in[CMD_VALID_BIT];
         end else if (frame_live) begin
            is_ram  = open_command[CMD_RAM_BIT];
            is_read = open_command[CMD_READ_BIT];
            addr    = open_command[5:1];
            // A burst walks the slots; a single access serves only the first slot.
            if (addr == BURST_ADDR) begin
               target = slot_index;
               hit    = is_ram ? (slot_index < RAM_DEPTH) : (slot_index < CLOCK_REGS);
            end else if (slot_index == 0) begin
               target = addr;
               hit    = is_ram ? (addr < RAM_DEPTH) : (addr < CLOCK_REGS);
            end
            if (hit) begin
               if (is_read) begin
                  reply.read_byte  = is_ram ? ram_shadow[target] : clock_shadow[target[2:0]];
                  reply.read_valid = 1'b1;
               end else if (!clock_shadow[WP_INDEX][7] || (!is_ram && target == WP_INDEX)) begin
                  if (is_ram) begin
                     ram_shadow[target] = item.byte_in;
                  end else begin
                     clock_shadow[target[2:0]] = item.byte_in;
                  end
                  reply.write_done = 1'b1;
               end
            end
            if (slot_index != POS_MAX) slot_index++;
         end
         owed_replies.push_back(reply);
      endfunction

      // Compare one accepted reply against the oldest one owed.
      function void check_reply(rsp_type got);
         rsp_type want;
         if (owed_replies.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected reply %h with nothing pending", got);
            return;
         end
         want = owed_replies.pop_front();
         if (got.read_byte !== want.read_byte || got.read_valid !== want.read_valid ||
             got.write_done !== want.write_done) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("reply mismatch: expected %h %b %b, got %h %b %b",
                        want.read_byte, want.read_valid, want.write_done,
                        got.read_byte, got.read_valid, got.write_done);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rtc_reply_tracker tracker = new();

   int send_idle_pct  = 19;
   int reply_idle_pct = 54;
   int items_sent     = 0;
   int hold_left      = 0;
   int cycle_count    = 0;
   bit hold_request   = 1'b0;

   rtc_three_wire_register_slave_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] make_command(logic is_ram, logic [4:0] addr, logic is_read);
      logic [7:0] cmd;
      cmd                = '0;
      cmd[CMD_VALID_BIT] = 1'b1;
      cmd[CMD_RAM_BIT]   = is_ram;
      cmd[5:1]           = addr;
      cmd[CMD_READ_BIT]  = is_read;
      return cmd;
   endfunction

   // Offer one item after a random idle stretch and wait until it is taken.
   task automatic send_item(input logic start, input logic [7:0] value);
      req_type item;
      item.frame_start = start;
      item.byte_in     = value;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_byte(item);
      items_sent++;
   endtask

   // One random frame: mostly well-formed commands with data slots, some noise.
   task automatic send_random_frame();
      int         roll;
      int         slots;
      logic       is_ram;
      logic       is_read;
      logic [4:0] addr;
      logic [4:0] target;
      logic [7:0] value;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         // A command without its valid bit, so the data after it is ignored.
         send_item(1'b1, {1'b0, 7'($urandom)});
         repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom));
      end else if (roll < 9) begin
         send_item(1'($urandom), 8'($urandom));
      end else begin
         is_ram  = 1'($urandom);
         is_read = 1'($urandom);
         roll    = $urandom_range(0, 99);
         if (roll < 30) addr = BURST_ADDR;
         else if (roll < 75) addr = 5'($urandom_range(0, CLOCK_REGS - 1));
         else addr = 5'($urandom_range(CLOCK_REGS, 30));
         send_item(1'b1, make_command(is_ram, addr, is_read));
         if (addr == BURST_ADDR)
            slots = ($urandom_range(0, 99) < 15) ? $urandom_range(20, 34) : $urandom_range(1, 10);
         else
            slots = $urandom_range(1, 3);
         for (int p = 0; p < slots; p++) begin
            value  = 8'($urandom);
            target = (addr == BURST_ADDR) ? 5'(p) : addr;
            // Keep write protection set only part of the time.
            if (!is_ram && target == WP_INDEX) value[7] = ($urandom_range(0, 99) < 25);
            send_item(1'b0, value);
         end
      end
   endtask

   // Result side: check every accepted reply and stall at random or on request.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) tracker.check_reply(rsp_data);
         if (hold_request) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= reply_idle_pct);
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Main sequence: reset, directed frames, then three random phases.
   initial begin
      int phase_target;
      req_valid <= 1'b0;
      req_data  <= '0;
      reset     <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // A data item with no frame open.
      send_item(1'b0, 8'hA5);
      // Commands without the valid bit leave the frame closed.
      send_item(1'b1, 8'h00);
      send_item(1'b0, 8'hFF);
      // Single clock write; the second slot is ignored.
      send_item(1'b1, make_command(SEL_CLOCK, 5'd0, DIR_WRITE));
      send_item(1'b0, 8'h5A);
      send_item(1'b0, 8'h11);
      send_item(1'b1, make_command(SEL_CLOCK, 5'd0, DIR_READ));
      send_item(1'b0, 8'h00);
      // Top RAM byte, written and read back.
      send_item(1'b1, make_command(SEL_RAM, 5'(RAM_DEPTH - 1), DIR_WRITE));
      send_item(1'b0, 8'hFF);
      send_item(1'b1, make_command(SEL_RAM, 5'(RAM_DEPTH - 1), DIR_READ));
      send_item(1'b0, 8'hFF);
      // Clock address past the register file.
      send_item(1'b1, make_command(SEL_CLOCK, 5'(CLOCK_REGS), DIR_WRITE));
      send_item(1'b0, 8'h33);
      // Set write protection, try a RAM write, then clear protection.
      send_item(1'b1, make_command(SEL_CLOCK, WP_INDEX, DIR_WRITE));
      send_item(1'b0, 8'h80);
      send_item(1'b1, make_command(SEL_RAM, 5'd0, DIR_WRITE));
      send_item(1'b0, 8'h77);
      send_item(1'b1, make_command(SEL_CLOCK, WP_INDEX, DIR_WRITE));
      send_item(1'b0, 8'h00);
      // Short clock burst read.
      send_item(1'b1, make_command(SEL_CLOCK, BURST_ADDR, DIR_READ));
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 19;
               reply_idle_pct = 54;
               hold_request   = 1'b1;
            end
            1: begin
               send_idle_pct  = 54;
               reply_idle_pct = 19;
            end
            default: begin
               send_idle_pct  = 0;
               reply_idle_pct = 0;
            end
         endcase
         phase_target = items_sent + RANDOM_ITEMS / 3;
         while (items_sent < phase_target) send_random_frame();
         // Pause the sender until every owed reply has come back.
         req_valid <= 1'b0;
         do @(posedge clock); while (tracker.owed_replies.size() != 0);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.fault_count == 0 && tracker.owed_replies.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
design/rtcs_pkg.sv
design/rtcs_frame.sv
design/rtcs_store.sv
design/rtc_three_wire_register_slave_unit.sv
design/rtcs_checker.sv
sim/tb_rtc_three_wire_register_slave_unit.sv
